// ===== sv/arm_thumb_format_classifier_macros.svh =====
// Assertion macros for the instruction format classifier.
`ifndef ARM_THUMB_FORMAT_CLASSIFIER_MACROS_SVH
`define ARM_THUMB_FORMAT_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/atfc_pkg.sv =====
// Format class codes and decode functions for the ARM/Thumb format classifier.
package atfc_pkg;

  typedef logic [4:0] format_class_t;

  // ARM classes
  localparam format_class_t CLS_ARM_BX       = 5'd0;
  localparam format_class_t CLS_ARM_BRANCH   = 5'd1;
  localparam format_class_t CLS_ARM_SWAP     = 5'd2;
  localparam format_class_t CLS_ARM_HALF     = 5'd3;
  localparam format_class_t CLS_ARM_PSR      = 5'd4;
  localparam format_class_t CLS_ARM_DATA     = 5'd5;
  localparam format_class_t CLS_ARM_MUL_LONG = 5'd6;
  localparam format_class_t CLS_ARM_MUL      = 5'd7;
  localparam format_class_t CLS_ARM_SINGLE   = 5'd8;
  localparam format_class_t CLS_ARM_BLOCK    = 5'd9;
  localparam format_class_t CLS_ARM_SWI      = 5'd10;
  localparam format_class_t CLS_ARM_UNDEF    = 5'd11;

  // Thumb classes
  localparam format_class_t CLS_T_MOVE_SHIFT = 5'd12;
  localparam format_class_t CLS_T_ADD_SUB    = 5'd13;
  localparam format_class_t CLS_T_IMM_OP     = 5'd14;
  localparam format_class_t CLS_T_ALU_OP     = 5'd15;
  localparam format_class_t CLS_T_HI_REG     = 5'd16;
  localparam format_class_t CLS_T_PC_LOAD    = 5'd17;
  localparam format_class_t CLS_T_LS_REG     = 5'd18;
  localparam format_class_t CLS_T_LS_SIGN    = 5'd19;
  localparam format_class_t CLS_T_LS_IMM     = 5'd20;
  localparam format_class_t CLS_T_LS_HALF    = 5'd21;
  localparam format_class_t CLS_T_SP_REL     = 5'd22;
  localparam format_class_t CLS_T_LOAD_ADDR  = 5'd23;
  localparam format_class_t CLS_T_ADD_SP     = 5'd24;
  localparam format_class_t CLS_T_PUSH_POP   = 5'd25;
  localparam format_class_t CLS_T_LS_MULTI   = 5'd26;
  localparam format_class_t CLS_T_COND_BR    = 5'd27;
  localparam format_class_t CLS_T_SWI        = 5'd28;
  localparam format_class_t CLS_T_BRANCH     = 5'd29;
  localparam format_class_t CLS_T_LONG_BL    = 5'd30;
  localparam format_class_t CLS_T_UNDEF      = 5'd31;

  // ARM match patterns
  localparam logic [23:0] ARM_BX_PATTERN = 24'b000100101111111111110001;
  localparam logic [31:0] ARM_PSR_MASK   = 32'h0D90_0000;
  localparam logic [31:0] ARM_PSR_MATCH  = 32'h0100_0000;

  // Thumb match patterns
  localparam logic [5:0] T_ALU_PREFIX    = 6'b010000;
  localparam logic [5:0] T_HI_PREFIX     = 6'b010001;
  localparam logic [4:0] T_PC_PREFIX     = 5'b01001;
  localparam logic [4:0] T_BRANCH_PREFIX = 5'b11100;

  // Classify a 32-bit ARM word; first matching test wins
  function automatic format_class_t arm_class(input logic [31:0] w);
    format_class_t cls;
    logic [1:0]    op;
    op = w[24:23];
    if (w[27:4] == ARM_BX_PATTERN) begin
      cls = CLS_ARM_BX;
    end else if (w[27:25] == 3'b101) begin
      cls = CLS_ARM_BRANCH;
    end else if ((w & ARM_PSR_MASK) == ARM_PSR_MATCH) begin
      if (w[7] && w[4] && !w[25]) begin
        cls = (w[6:5] == 2'b00) ? CLS_ARM_SWAP : CLS_ARM_HALF;
      end else begin
        cls = CLS_ARM_PSR;
      end
    end else if (w[27:26] == 2'b00) begin
      if (w[7] && !w[4]) begin
        if (w[25] || w[20] || op != 2'b10) begin
          cls = CLS_ARM_DATA;
        end else begin
          cls = w[23] ? CLS_ARM_MUL_LONG : CLS_ARM_MUL;
        end
      end else if (w[7] && w[4]) begin
        if (w[7:4] == 4'b1001) begin
          if (w[25]) begin
            cls = CLS_ARM_DATA;
          end else if (op == 2'b10) begin
            cls = CLS_ARM_SWAP;
          end else begin
            cls = w[23] ? CLS_ARM_MUL_LONG : CLS_ARM_MUL;
          end
        end else begin
          cls = w[25] ? CLS_ARM_DATA : CLS_ARM_HALF;
        end
      end else begin
        cls = CLS_ARM_DATA;
      end
    end else if (w[27:26] == 2'b01) begin
      cls = CLS_ARM_SINGLE;
    end else if (w[27:25] == 3'b100) begin
      cls = CLS_ARM_BLOCK;
    end else if (w[27:24] == 4'hF) begin
      cls = CLS_ARM_SWI;
    end else begin
      cls = CLS_ARM_UNDEF;
    end
    return cls;
  endfunction

  // Classify a 16-bit Thumb halfword; first matching test wins
  function automatic format_class_t thumb_class(input logic [15:0] w);
    format_class_t cls;
    if (w[15:13] == 3'd0) begin
      cls = (w[12:11] == 2'b11) ? CLS_T_ADD_SUB : CLS_T_MOVE_SHIFT;
    end else if (w[15:13] == 3'd1) begin
      cls = CLS_T_IMM_OP;
    end else if (w[15:10] == T_ALU_PREFIX) begin
      cls = CLS_T_ALU_OP;
    end else if (w[15:10] == T_HI_PREFIX) begin
      cls = CLS_T_HI_REG;
    end else if (w[15:11] == T_PC_PREFIX) begin
      cls = CLS_T_PC_LOAD;
    end else if (w[15:12] == 4'h5) begin
      cls = w[9] ? CLS_T_LS_SIGN : CLS_T_LS_REG;
    end else if (w[15:13] == 3'd3) begin
      cls = CLS_T_LS_IMM;
    end else if (w[15:12] == 4'h8) begin
      cls = CLS_T_LS_HALF;
    end else if (w[15:12] == 4'h9) begin
      cls = CLS_T_SP_REL;
    end else if (w[15:12] == 4'hA) begin
      cls = CLS_T_LOAD_ADDR;
    end else if (w[15:12] == 4'hB) begin
      // only bits 11..9 all clear give the SP offset form
      cls = (w[11:9] == 3'b000) ? CLS_T_ADD_SP : CLS_T_PUSH_POP;
    end else if (w[15:12] == 4'hC) begin
      cls = CLS_T_LS_MULTI;
    end else if (w[15:12] == 4'hD) begin
      cls = (w[11:8] == 4'hF) ? CLS_T_SWI : CLS_T_COND_BR;
    end else if (w[15:11] == T_BRANCH_PREFIX) begin
      cls = CLS_T_BRANCH;
    end else if (w[15:12] == 4'hF) begin
      cls = CLS_T_LONG_BL;
    end else begin
      cls = CLS_T_UNDEF;
    end
    return cls;
  endfunction

endpackage

// ===== sv/arm_thumb_format_classifier.sv =====
// Top level of the ARM/Thumb instruction format classifier.
// Throughput: one instruction per cycle; busy stays low, so start may be high every cycle.
// Path: input register, one pass of pattern-test logic, result register.
// Reset (rst, synchronous, active high) clears the valid flags; no beat is
// pending afterwards. The receiver cannot stall: strobe marks each result for one cycle.
`include "arm_thumb_format_classifier_macros.svh"

module arm_thumb_format_classifier
  import atfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [31:0]   instruction_word,
  input  logic          action,
  output logic          strobe,
  output logic [4:0]    format_class
);

  logic          in_valid;
  logic [31:0]   in_word;
  logic          in_action;
  format_class_t format_class_next;

  // Never hold off an input beat
  assign busy = 1'b0;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_word   <= instruction_word;
      in_action <= action;
    end
  end

  // Classify by mode; Thumb looks at the low halfword only
  always_comb begin
    if (in_action) begin
      format_class_next = thumb_class(in_word[15:0]);
    end else begin
      format_class_next = arm_class(in_word);
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= in_valid;
    end
    if (in_valid) begin
      format_class <= format_class_next;
    end
  end

  // Checks
  `ASSERT_NEXT(a_accept_fills, clk, rst, start && !busy, in_valid)
  `ASSERT_NEXT(a_stage_strobes, clk, rst, in_valid, strobe)
  `ASSERT_NEXT(a_no_phantom, clk, rst, !in_valid, !strobe)
  `ASSERT_NEXT(a_thumb_range, clk, rst, in_valid && in_action, format_class >= CLS_T_MOVE_SHIFT)
  `ASSERT_NEXT(a_arm_range, clk, rst, in_valid && !in_action, format_class <= CLS_ARM_UNDEF)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ARM/Thumb instruction format classifier.
`timescale 1ns / 100ps

module tb_top
  import atfc_pkg::*;
();

  // Directed stimulus row; a fixed class overrides the predictor
  typedef struct {
    logic [31:0]   word;
    logic          thumb;
    bit            fixed;
    format_class_t cls;
  } stim_row_t;

  // One outstanding decode with its expected class
  typedef struct {
    logic [31:0]   word;
    logic          thumb;
    format_class_t cls;
  } class_entry_t;

  // Shapes of random ARM words, each aimed at one region of the decode chain
  typedef enum int unsigned {
    ARM_ANY,
    ARM_BX_EXACT,
    ARM_BX_NEAR,
    ARM_BRANCH_SPACE,
    ARM_STATUS_SPACE,
    ARM_EXTRA_LOADS,
    ARM_MULTIPLY_SPACE,
    ARM_SHIFT_BY_REG,
    ARM_SINGLE_SPACE,
    ARM_BLOCK_SPACE,
    ARM_SWI_SPACE
  } arm_shape_e;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic          clk;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [31:0]   instruction_word = '0;
  logic          action = 1'b0;
  logic          strobe;
  logic [4:0]    format_class;

  class_entry_t  expected_classes[$];
  int unsigned   error_count = 0;
  int unsigned   arm_count = 0;
  int unsigned   thumb_count = 0;
  logic [31:0]   classes_seen = '0;

  stim_row_t directed_rows [25] = '{
    '{32'hE12F_FF1E, 1'b0, 1'b1, CLS_ARM_BX},
    '{32'hEA00_0010, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE101_2092, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE1D0_10B0, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE10F_0000, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE081_0002, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE000_0291, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE081_0392, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE100_0080, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE591_0000, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hE8BD_000F, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hEF00_0001, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hEE00_0000, 1'b0, 1'b1, CLS_ARM_UNDEF},
    '{32'h0000_0000, 1'b0, 1'b0, CLS_ARM_BX},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, CLS_ARM_SWI},
    '{32'hFFFF_0000, 1'b1, 1'b1, CLS_T_MOVE_SHIFT},
    '{32'h0000_1800, 1'b1, 1'b0, CLS_ARM_BX},
    '{32'h0000_4000, 1'b1, 1'b0, CLS_ARM_BX},
    '{32'h0000_4770, 1'b1, 1'b0, CLS_ARM_BX},
    '{32'h0000_5200, 1'b1, 1'b0, CLS_ARM_BX},
    '{32'h0000_B000, 1'b1, 1'b1, CLS_T_ADD_SP},
    '{32'h0000_B200, 1'b1, 1'b1, CLS_T_PUSH_POP},
    '{32'h0000_DF00, 1'b1, 1'b0, CLS_ARM_BX},
    '{32'h0000_E800, 1'b1, 1'b1, CLS_T_UNDEF},
    '{32'h0000_FFFF, 1'b1, 1'b1, CLS_T_LONG_BL}
  };

  arm_thumb_format_classifier dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .instruction_word (instruction_word),
    .action           (action),
    .strobe           (strobe),
    .format_class     (format_class)
  );

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Classify a 32-bit ARM word; earlier tests take priority over later ones
  function automatic format_class_t classify_arm_word(input logic [31:0] w);
    logic [1:0] op;
    op = w[24:23];
    if (w[27:4] == ARM_BX_PATTERN) return CLS_ARM_BX;
    if (w[27:25] == 3'b101) return CLS_ARM_BRANCH;
    if ((w & ARM_PSR_MASK) == ARM_PSR_MATCH) begin
      if (w[7] && w[4] && !w[25]) return (w[6:5] == 2'b00) ? CLS_ARM_SWAP : CLS_ARM_HALF;
      return CLS_ARM_PSR;
    end
    if (w[27:26] == 2'b00) begin
      if (w[7] && !w[4]) begin
        if (w[25]) return CLS_ARM_DATA;
        if (w[20] && op == 2'b10) return CLS_ARM_DATA;
        if (op != 2'b10) return CLS_ARM_DATA;
        return w[23] ? CLS_ARM_MUL_LONG : CLS_ARM_MUL;
      end
      if (w[7] && w[4]) begin
        if (w[7:4] == 4'b1001) begin
          if (w[25]) return CLS_ARM_DATA;
          if (op == 2'b10) return CLS_ARM_SWAP;
          return w[23] ? CLS_ARM_MUL_LONG : CLS_ARM_MUL;
        end
        return w[25] ? CLS_ARM_DATA : CLS_ARM_HALF;
      end
      return CLS_ARM_DATA;
    end
    if (w[27:26] == 2'b01) return CLS_ARM_SINGLE;
    if (w[27:25] == 3'b100) return CLS_ARM_BLOCK;
    if (w[27:24] == 4'hF) return CLS_ARM_SWI;
    return CLS_ARM_UNDEF;
  endfunction

  // Classify a Thumb halfword in the same priority order
  function automatic format_class_t classify_thumb_half(input logic [15:0] h);
    if (h[15:13] == 3'b000) return (h[12:11] == 2'b11) ? CLS_T_ADD_SUB : CLS_T_MOVE_SHIFT;
    if (h[15:13] == 3'b001) return CLS_T_IMM_OP;
    if (h[15:10] == T_ALU_PREFIX) return CLS_T_ALU_OP;
    if (h[15:10] == T_HI_PREFIX) return CLS_T_HI_REG;
    if (h[15:11] == T_PC_PREFIX) return CLS_T_PC_LOAD;
    if (h[15:12] == 4'h5) return h[9] ? CLS_T_LS_SIGN : CLS_T_LS_REG;
    if (h[15:13] == 3'b011) return CLS_T_LS_IMM;
    case (h[15:12])
      4'h8: return CLS_T_LS_HALF;
      4'h9: return CLS_T_SP_REL;
      4'hA: return CLS_T_LOAD_ADDR;
      4'hB: return (h[11:9] == 3'b000) ? CLS_T_ADD_SP : CLS_T_PUSH_POP;
      4'hC: return CLS_T_LS_MULTI;
      4'hD: return (h[11:8] == 4'hF) ? CLS_T_SWI : CLS_T_COND_BR;
      default: ;
    endcase
    if (h[15:11] == T_BRANCH_PREFIX) return CLS_T_BRANCH;
    if (h[15:12] == 4'hF) return CLS_T_LONG_BL;
    return CLS_T_UNDEF;
  endfunction

  // Pick the decode by mode; Thumb sees only the low halfword
  function automatic format_class_t predict_format_class(input logic [31:0] w,
                                                         input logic thumb);
    return thumb ? classify_thumb_half(w[15:0]) : classify_arm_word(w);
  endfunction

  // Random ARM word biased toward one region of the decode chain
  function automatic logic [31:0] make_arm_word();
    logic [31:0] w;
    arm_shape_e  shape;
    w = $urandom;
    shape = arm_shape_e'($urandom_range(ARM_ANY, ARM_SWI_SPACE));
    case (shape)
      ARM_BX_EXACT:       w[27:4] = ARM_BX_PATTERN;
      ARM_BX_NEAR:        w[27:4] = ARM_BX_PATTERN ^ (24'd1 << $urandom_range(0, 23));
      ARM_BRANCH_SPACE:   w[27:25] = 3'b101;
      ARM_STATUS_SPACE: begin
        w[27:24] = 4'b0001;
        w[23]    = 1'b0;
        w[20]    = 1'b0;
      end
      ARM_EXTRA_LOADS: begin
        w[27:26] = 2'b00;
        w[7]     = 1'b1;
        w[4]     = 1'b1;
      end
      ARM_MULTIPLY_SPACE: begin
        w[27:26] = 2'b00;
        w[7:4]   = 4'b1001;
        w[25]    = $urandom_range(0, 3) == 0;
      end
      ARM_SHIFT_BY_REG: begin
        w[27:26] = 2'b00;
        w[7]     = 1'b1;
        w[4]     = 1'b0;
      end
      ARM_SINGLE_SPACE:   w[27:26] = 2'b01;
      ARM_BLOCK_SPACE:    w[27:25] = 3'b100;
      ARM_SWI_SPACE:      w[27:24] = 4'hF;
      default: ;
    endcase
    return w;
  endfunction

  // Random Thumb word; split the prefixes whose class hangs on a few low bits
  function automatic logic [31:0] make_thumb_word();
    logic [31:0] w;
    w = $urandom;
    if (w[15:12] == 4'hB && $urandom_range(0, 1)) w[11:9] = 3'b000;
    if (w[15:12] == 4'hD && $urandom_range(0, 1)) w[11:8] = 4'hF;
    return w;
  endfunction

  // Drive one beat, wait for acceptance, queue its class, then idle for the gap if it is nonzero
  task automatic issue_instruction(input logic [31:0] word, input logic thumb,
                                   input bit use_fixed, input format_class_t fixed_cls,
                                   input int unsigned gap);
    class_entry_t entry;
    start            <= 1'b1;
    instruction_word <= word;
    action           <= thumb;
    do @(posedge clk); while (busy);
    entry.word  = word;
    entry.thumb = thumb;
    entry.cls   = use_fixed ? fixed_cls : predict_format_class(word, thumb);
    expected_classes.push_back(entry);
    if (thumb) thumb_count++;
    else arm_count++;
    if (gap != 0) begin
      start            <= 1'b0;
      instruction_word <= $urandom;
      action           <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every queued class has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_classes.size() != 0);
  endtask

  // Check each result beat against the oldest queued class
  always @(posedge clk) begin
    class_entry_t entry;
    if (!rst && strobe) begin
      if (expected_classes.size() == 0) begin
        $error("format_class: unexpected beat, actual %0d", format_class);
        error_count++;
      end else begin
        entry = expected_classes.pop_front();
        classes_seen[format_class] = 1'b1;
        if (format_class !== entry.cls) begin
          $error("format_class: expected %0d, actual %0d (word %h, thumb %0b)",
                 entry.cls, format_class, entry.word, entry.thumb);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("arm_thumb_format_classifier: mismatch");
    $finish;
  end

  // Reset, directed table, random beats, drain and report
  initial begin
    logic [31:0] word;
    logic        thumb;
    bit          burst;
    int unsigned gap;
    burst = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      issue_instruction(directed_rows[i].word, directed_rows[i].thumb,
                        directed_rows[i].fixed, directed_rows[i].cls,
                        $urandom_range(0, 5));
    end
    wait_for_drain();

    // Random beats in stretches of back-to-back or gapped traffic
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) burst = $urandom_range(0, 2) == 0;
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      gap   = burst ? 0 : $urandom_range(0, 5);
      thumb = 1'($urandom_range(0, 1));
      word  = thumb ? make_thumb_word() : make_arm_word();
      issue_instruction(word, thumb, 1'b0, CLS_ARM_BX, gap);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_classes.size() != 0) begin
      $error("format_class: %0d beats never arrived", expected_classes.size());
      error_count++;
    end

    $display("Decoded %0d ARM and %0d Thumb words; %0d of 32 format classes returned.",
             arm_count, thumb_count, $countones(classes_seen));
    if (error_count == 0) begin
      $display("arm_thumb_format_classifier: match");
    end else begin
      $display("arm_thumb_format_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ===== arm_thumb_format_classifier.f =====
+incdir+sv
sv/atfc_pkg.sv
sv/arm_thumb_format_classifier.sv
tb/tb_top.sv
